[hw/rtl/assert_macros.svh]
// assertion macros for the rtl of the radial vision mask
// no dependencies; included by files that carry concurrent checks
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while reset is asserted
`define ASSERT_IMPLIES(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled while reset is asserted
`define ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

[hw/rtl/rvm_pkg.sv]
// package for the radial vision mask: widths, register indexes, zone codes
// and the shared restoring-division step; no dependencies
`timescale 1ns / 1ps

package rvm_pkg;

    localparam int COORD_W   = 12;  // pixel coordinate width, 8 to 13
    localparam int CENTER_W  = 14;
    localparam int RAD_W     = 13;
    localparam int ALPHA_W   = 8;
    localparam int COLOR_W   = 32;
    localparam int CFG_IDX_W = 3;

    // |pixel - centre| stays below 2^14 for any coordinate width up to 13
    localparam int DX_W   = 15;
    localparam int MAG_W  = 14;
    localparam int SQ_W   = 2 * MAG_W;
    localparam int D2_W   = SQ_W + 1;
    localparam int RSQ_W  = 2 * RAD_W;
    localparam int NUM_W  = RSQ_W + ALPHA_W;
    localparam int QUO_W  = ALPHA_W;
    localparam int QIDX_W = 3;
    localparam int DIV_BITS   = 2;
    localparam int DIV_STAGES = QUO_W / DIV_BITS;
    localparam int PROD_W = 2 * ALPHA_W;

    localparam logic [PROD_W-1:0] ROUND_BIAS = PROD_W'(127);

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_CENTER_X      = 3'd0,
        CFG_CENTER_Y      = 3'd1,
        CFG_INNER_RADIUS  = 3'd2,
        CFG_OUTER_RADIUS  = 3'd3,
        CFG_OUTSIDE_ALPHA = 3'd4,
        CFG_MASK_COLOR    = 3'd5
    } cfg_idx_t;

    typedef enum logic [1:0] {
        ZONE_INSIDE  = 2'd0,
        ZONE_RAMP    = 2'd1,
        ZONE_OUTSIDE = 2'd2
    } zone_t;

    typedef struct packed {
        logic [NUM_W-1:0]   rem;
        logic [QUO_W-1:0]   quo;
        logic [RSQ_W-1:0]   den;
        zone_t              zone;
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] y;
    } div_stage_t;

    // one restoring step: tries den << pos against the running remainder
    function automatic div_stage_t div_step(input div_stage_t d,
                                            input logic [QIDX_W-1:0] pos);
        logic [NUM_W:0] trial;
        div_stage_t     r;
        r     = d;
        trial = (NUM_W + 1)'(d.den) << pos;
        if ({1'b0, d.rem} >= trial) begin
            r.rem      = d.rem - trial[NUM_W-1:0];
            r.quo[pos] = 1'b1;
        end
        return r;
    endfunction

endpackage

[hw/rtl/radial_vision_mask_alpha_top.sv]
// Radial vision mask, one pixel per clock. A pixel request enters on every cycle
// in which s_ready is high and passes through eleven register stages to the m_ side:
// absolute offset, squares, distance sum, zone test, numerator, four stages of
// two-bit restoring division, colour-alpha multiply and the output register.
// Sustained rate is one pixel per cycle while m_ready stays high, as the divider is fully pipelined;
// a stalled m_ready back-pressures stage by stage and bubbles are squeezed out.
// Pixels whose effective alpha rounds to zero are consumed but produce no
// result. Configuration registers must only be written while the pipe is empty.
// Depends on rvm_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module radial_vision_mask_alpha_top (
    input  logic                               aclk,
    input  logic                               aresetn,
    // configuration write channel
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [rvm_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [rvm_pkg::COLOR_W-1:0]        cfg_wdata,
    // pixel requests
    input  logic                               s_valid,
    output logic                               s_ready,
    input  logic [rvm_pkg::COORD_W-1:0]        s_pixel_x,
    input  logic [rvm_pkg::COORD_W-1:0]        s_pixel_y,
    // paint results
    output logic                               m_valid,
    input  logic                               m_ready,
    output logic [rvm_pkg::COORD_W-1:0]        m_out_x,
    output logic [rvm_pkg::COORD_W-1:0]        m_out_y,
    output logic [rvm_pkg::ALPHA_W-1:0]        m_paint_alpha
);

    localparam int NDIV = rvm_pkg::DIV_STAGES;

    // configuration registers
    logic signed [rvm_pkg::CENTER_W-1:0] center_x_reg, center_y_reg;
    logic [rvm_pkg::RAD_W-1:0]           inner_radius_reg, outer_radius_reg;
    logic [rvm_pkg::ALPHA_W-1:0]         outside_alpha_reg;
    logic [rvm_pkg::COLOR_W-1:0]         mask_color_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            center_x_reg      <= '0;
            center_y_reg      <= '0;
            inner_radius_reg  <= '0;
            outer_radius_reg  <= '0;
            outside_alpha_reg <= '0;
            mask_color_reg    <= '0;
        end else if (cfg_valid && cfg_ready) begin
            unique case (rvm_pkg::cfg_idx_t'(cfg_index))
                rvm_pkg::CFG_CENTER_X: begin
                    center_x_reg <= cfg_wdata[rvm_pkg::CENTER_W-1:0];
                end
                rvm_pkg::CFG_CENTER_Y: begin
                    center_y_reg <= cfg_wdata[rvm_pkg::CENTER_W-1:0];
                end
                rvm_pkg::CFG_INNER_RADIUS: begin
                    inner_radius_reg <= cfg_wdata[rvm_pkg::RAD_W-1:0];
                end
                rvm_pkg::CFG_OUTER_RADIUS: begin
                    outer_radius_reg <= cfg_wdata[rvm_pkg::RAD_W-1:0];
                end
                rvm_pkg::CFG_OUTSIDE_ALPHA: begin
                    outside_alpha_reg <= cfg_wdata[rvm_pkg::ALPHA_W-1:0];
                end
                rvm_pkg::CFG_MASK_COLOR: begin
                    mask_color_reg <= cfg_wdata;
                end
                default: begin
                end
            endcase
        end
    end

    // stage enables, chained back from the output register
    logic st1_en, st2_en, st3_en, st4_en, st6_en, out_en;
    logic div_en [NDIV+1];

    logic st1_valid_reg, st2_valid_reg, st3_valid_reg, st4_valid_reg, st6_valid_reg;
    logic div_valid_reg [NDIV+1];
    logic m_valid_reg;

    // stage 1: absolute offsets from the centre
    logic [rvm_pkg::COORD_W-1:0] st1_x_reg, st1_y_reg;
    logic [rvm_pkg::MAG_W-1:0]   st1_ux_reg, st1_uy_reg;
    logic [rvm_pkg::DX_W-1:0]    dx, dy;
    logic [rvm_pkg::MAG_W-1:0]   ux_next, uy_next;

    assign dx = {{(rvm_pkg::DX_W - rvm_pkg::COORD_W){1'b0}}, s_pixel_x}
              - {{(rvm_pkg::DX_W - rvm_pkg::CENTER_W){center_x_reg[rvm_pkg::CENTER_W-1]}},
                 center_x_reg};
    assign dy = {{(rvm_pkg::DX_W - rvm_pkg::COORD_W){1'b0}}, s_pixel_y}
              - {{(rvm_pkg::DX_W - rvm_pkg::CENTER_W){center_y_reg[rvm_pkg::CENTER_W-1]}},
                 center_y_reg};
    assign ux_next = dx[rvm_pkg::DX_W-1] ? rvm_pkg::MAG_W'(-dx) : rvm_pkg::MAG_W'(dx);
    assign uy_next = dy[rvm_pkg::DX_W-1] ? rvm_pkg::MAG_W'(-dy) : rvm_pkg::MAG_W'(dy);

    // stage 2: squares of offsets and radii
    logic [rvm_pkg::COORD_W-1:0] st2_x_reg, st2_y_reg;
    logic [rvm_pkg::SQ_W-1:0]    st2_uxsq_reg, st2_uysq_reg;
    logic [rvm_pkg::RSQ_W-1:0]   st2_in2_reg, st2_out2_reg;

    // stage 3: squared distance and ramp width
    logic [rvm_pkg::COORD_W-1:0] st3_x_reg, st3_y_reg;
    logic [rvm_pkg::D2_W-1:0]    st3_d2_reg;
    logic [rvm_pkg::RSQ_W-1:0]   st3_in2_reg, st3_out2_reg, st3_den_reg;

    // stage 4: zone and offset into the ramp
    logic [rvm_pkg::COORD_W-1:0] st4_x_reg, st4_y_reg;
    rvm_pkg::zone_t              st4_zone_reg, zone_next;
    logic [rvm_pkg::RSQ_W-1:0]   st4_diff_reg, st4_den_reg;

    always_comb begin
        priority if (st3_d2_reg <= rvm_pkg::D2_W'(st3_in2_reg)) begin
            zone_next = rvm_pkg::ZONE_INSIDE;
        end else if (st3_d2_reg >= rvm_pkg::D2_W'(st3_out2_reg)) begin
            zone_next = rvm_pkg::ZONE_OUTSIDE;
        end else begin
            zone_next = rvm_pkg::ZONE_RAMP;
        end
    end

    // divider chain: entry 0 holds the rounded numerator, then two quotient bits a stage
    rvm_pkg::div_stage_t div_reg [NDIV+1];
    rvm_pkg::div_stage_t div0_next;

    always_comb begin
        div0_next.rem  = rvm_pkg::NUM_W'(outside_alpha_reg) * rvm_pkg::NUM_W'(st4_diff_reg)
                       + rvm_pkg::NUM_W'(st4_den_reg >> 1);
        div0_next.quo  = '0;
        div0_next.den  = st4_den_reg;
        div0_next.zone = st4_zone_reg;
        div0_next.x    = st4_x_reg;
        div0_next.y    = st4_y_reg;
    end

    // stage 6: base alpha times colour alpha, with rounding bias
    logic [rvm_pkg::COORD_W-1:0] st6_x_reg, st6_y_reg;
    logic [rvm_pkg::PROD_W-1:0]  st6_prod_reg;
    logic [rvm_pkg::ALPHA_W-1:0] base_alpha;
    rvm_pkg::div_stage_t         div_last;

    assign div_last = div_reg[NDIV];

    always_comb begin
        unique case (div_last.zone)
            rvm_pkg::ZONE_INSIDE:  base_alpha = '0;
            rvm_pkg::ZONE_OUTSIDE: base_alpha = outside_alpha_reg;
            rvm_pkg::ZONE_RAMP:    base_alpha = div_last.quo;
            default:               base_alpha = '0;
        endcase
    end

    // divide by 255 through x + (x >> 8) + 1, exact for the biased products here, which keep the sum below 2^16
    logic [rvm_pkg::PROD_W-1:0]  div255_sum;
    logic [rvm_pkg::ALPHA_W-1:0] eff_alpha;

    assign div255_sum = st6_prod_reg + (st6_prod_reg >> rvm_pkg::ALPHA_W) + rvm_pkg::PROD_W'(1);
    assign eff_alpha  = div255_sum[rvm_pkg::PROD_W-1:rvm_pkg::ALPHA_W];

    // enables
    assign out_en        = !m_valid_reg || m_ready;
    assign st6_en        = !st6_valid_reg || out_en;
    assign div_en[NDIV]  = !div_valid_reg[NDIV] || st6_en;
    assign st4_en        = !st4_valid_reg || div_en[0];
    assign st3_en        = !st3_valid_reg || st4_en;
    assign st2_en        = !st2_valid_reg || st3_en;
    assign st1_en        = !st1_valid_reg || st2_en;
    assign s_ready       = st1_en;

    // front stages
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st1_valid_reg <= 1'b0;
            st2_valid_reg <= 1'b0;
            st3_valid_reg <= 1'b0;
            st4_valid_reg <= 1'b0;
        end else begin
            if (st1_en) st1_valid_reg <= s_valid;
            if (st2_en) st2_valid_reg <= st1_valid_reg;
            if (st3_en) st3_valid_reg <= st2_valid_reg;
            if (st4_en) st4_valid_reg <= st3_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (st1_en) begin
            st1_x_reg  <= s_pixel_x;
            st1_y_reg  <= s_pixel_y;
            st1_ux_reg <= ux_next;
            st1_uy_reg <= uy_next;
        end
        if (st2_en) begin
            st2_x_reg    <= st1_x_reg;
            st2_y_reg    <= st1_y_reg;
            st2_uxsq_reg <= rvm_pkg::SQ_W'(st1_ux_reg) * rvm_pkg::SQ_W'(st1_ux_reg);
            st2_uysq_reg <= rvm_pkg::SQ_W'(st1_uy_reg) * rvm_pkg::SQ_W'(st1_uy_reg);
            st2_in2_reg  <= rvm_pkg::RSQ_W'(inner_radius_reg) * rvm_pkg::RSQ_W'(inner_radius_reg);
            st2_out2_reg <= rvm_pkg::RSQ_W'(outer_radius_reg) * rvm_pkg::RSQ_W'(outer_radius_reg);
        end
        if (st3_en) begin
            st3_x_reg    <= st2_x_reg;
            st3_y_reg    <= st2_y_reg;
            st3_d2_reg   <= rvm_pkg::D2_W'(st2_uxsq_reg) + rvm_pkg::D2_W'(st2_uysq_reg);
            st3_in2_reg  <= st2_in2_reg;
            st3_out2_reg <= st2_out2_reg;
            st3_den_reg  <= st2_out2_reg - st2_in2_reg;
        end
        if (st4_en) begin
            st4_x_reg    <= st3_x_reg;
            st4_y_reg    <= st3_y_reg;
            st4_zone_reg <= zone_next;
            st4_diff_reg <= rvm_pkg::RSQ_W'(st3_d2_reg - rvm_pkg::D2_W'(st3_in2_reg));
            st4_den_reg  <= st3_den_reg;
        end
    end

    // numerator stage
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            div_valid_reg[0] <= 1'b0;
        end else if (div_en[0]) begin
            div_valid_reg[0] <= st4_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (div_en[0]) begin
            div_reg[0] <= div0_next;
        end
    end

    // quotient stages, most significant bits first
    for (genvar g = 1; g <= NDIV; g++) begin : g_div
        localparam int HI = rvm_pkg::QUO_W - rvm_pkg::DIV_BITS * (g - 1) - 1;

        rvm_pkg::div_stage_t step_hi, step_lo;

        assign div_en[g-1] = !div_valid_reg[g-1] || div_en[g];
        assign step_hi = rvm_pkg::div_step(div_reg[g-1], rvm_pkg::QIDX_W'(HI));
        assign step_lo = rvm_pkg::div_step(step_hi, rvm_pkg::QIDX_W'(HI - 1));

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                div_valid_reg[g] <= 1'b0;
            end else if (div_en[g]) begin
                div_valid_reg[g] <= div_valid_reg[g-1];
            end
        end

        always_ff @(posedge aclk) begin
            if (div_en[g]) begin
                div_reg[g] <= step_lo;
            end
        end
    end

    // colour-alpha stage and output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st6_valid_reg <= 1'b0;
            m_valid_reg   <= 1'b0;
        end else begin
            if (st6_en) st6_valid_reg <= div_valid_reg[NDIV];
            // a pixel whose alpha rounds to zero is dropped here
            if (out_en) m_valid_reg <= st6_valid_reg && (eff_alpha != '0);
        end
    end

    always_ff @(posedge aclk) begin
        if (st6_en) begin
            st6_x_reg    <= div_last.x;
            st6_y_reg    <= div_last.y;
            st6_prod_reg <= rvm_pkg::PROD_W'(base_alpha)
                          * rvm_pkg::PROD_W'(mask_color_reg[rvm_pkg::ALPHA_W-1:0])
                          + rvm_pkg::ROUND_BIAS;
        end
        if (out_en) begin
            m_out_x       <= st6_x_reg;
            m_out_y       <= st6_y_reg;
            m_paint_alpha <= eff_alpha;
        end
    end

    assign m_valid = m_valid_reg;

    // checks
    `ASSERT_NEXT(a_request_enters, aclk, aresetn, s_valid && s_ready, st1_valid_reg, "accepted request did not enter stage 1")
    `ASSERT_IMPLIES(a_ramp_den_nonzero, aclk, aresetn, st4_valid_reg && (st4_zone_reg == rvm_pkg::ZONE_RAMP), st4_den_reg != '0, "ramp zone with empty ramp width")
    `ASSERT_IMPLIES(a_div_rem_bound, aclk, aresetn, div_valid_reg[NDIV] && (div_last.zone == rvm_pkg::ZONE_RAMP), div_last.rem < rvm_pkg::NUM_W'(div_last.den), "division remainder not below divisor")
    `ASSERT_NEXT(a_stage6_held, aclk, aresetn, st6_valid_reg && !st6_en, st6_valid_reg && $stable(st6_prod_reg), "stalled stage 6 lost its contents")

endmodule
